>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros: shared assertion macros
// clocked on aclk, disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

>>> rtl/core/ptbl_pkg.sv
// ----------------------------------------------------------------------------
// ptbl_pkg: shared types and constants of the probe table
// slot geometry, entry layout, request and status codes
// ----------------------------------------------------------------------------
package ptbl_pkg;

    localparam int SLOT_BITS   = 9;
    localparam int SLOT_COUNT  = 2 ** SLOT_BITS;
    localparam int KEY_BITS    = 48;
    localparam int VALUE_BITS  = 64;
    localparam int ENTRY_BITS  = KEY_BITS + VALUE_BITS;
    localparam int HOME_SHIFT  = 4;

    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        STAT_HIT      = 3'd0,
        STAT_MISS     = 3'd1,
        STAT_INSERTED = 3'd2,
        STAT_PRESENT  = 3'd3,
        STAT_FULL     = 3'd4,
        STAT_NULL     = 3'd5,
        STAT_CLEARED  = 3'd6
    } status_t;

    typedef struct packed {
        logic match;
        logic empty;
        logic exhausted;
    } probe_res_t;

endpackage

>>> rtl/core/ptbl_ram.sv
// ----------------------------------------------------------------------------
// ptbl_ram: generic single-port-write, single-port-read memory
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
module ptbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/core/ptbl_probe.sv
// ----------------------------------------------------------------------------
// ptbl_probe: probe step unit
// compares one slot against the search key and advances the probe position
// ----------------------------------------------------------------------------
module ptbl_probe
    import ptbl_pkg::*;
(
    input  logic [KEY_BITS-1:0]  slot_key,
    input  logic [KEY_BITS-1:0]  search_key,
    input  logic [SLOT_BITS-1:0] pos_reg,
    input  logic [SLOT_BITS-1:0] cnt_reg,
    output probe_res_t           res,
    output logic [SLOT_BITS-1:0] pos_next,
    output logic [SLOT_BITS-1:0] cnt_next
);

    always_comb begin
        res.match     = (slot_key == search_key);
        res.empty     = (slot_key == '0);
        res.exhausted = (cnt_reg == {SLOT_BITS{1'b1}});
        // power-of-two slot count: wrap is the natural overflow
        pos_next      = pos_reg + 1'b1;
        cnt_next      = cnt_reg + 1'b1;
    end

endmodule

>>> rtl/core/pointer_keyed_probe_table.sv
// ----------------------------------------------------------------------------
// pointer_keyed_probe_table: open-addressed hash table, linear probing
// Input channel s_*: one request item (lookup, insert if absent, clear).
// Result channel m_*: exactly one result item per request, in order.
// The home slot is key bits [12:4]; the probe walks forward one slot at a
// time with wrap until it finds the key or an empty slot, or has seen all
// 512 slots. Each probe is one read of the slot memory plus one compare in
// the shared probe unit.
// A null key (STAT_NULL) or an unused request type (STAT_MISS) goes straight
// to the result without probing; clear sweeps all 512 slots empty.
// s_ready is high only while the sequencer is idle, so a new item is not
// accepted until the result of the previous one has been registered.
// After reset the block sweeps all 512 slots empty, one per cycle, before
// s_ready first rises.
// A result waits in the output register while m_ready is low; the next item
// may be accepted meanwhile, and its result is held back until the
// output register is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pointer_keyed_probe_table
    import ptbl_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_req_type,
    input  logic [KEY_BITS-1:0]   s_key,
    input  logic [VALUE_BITS-1:0] s_entry_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [2:0]            m_status,
    output logic [VALUE_BITS-1:0] m_found_value
);

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_READ,
        S_CMP,
        S_RESP
    } state_t;

    state_t                 state_reg;
    logic [SLOT_BITS-1:0]   pos_reg;
    logic [SLOT_BITS-1:0]   cnt_reg;
    logic [SLOT_BITS-1:0]   pos_next;
    logic [SLOT_BITS-1:0]   cnt_next;
    req_t                   req_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [VALUE_BITS-1:0]  value_reg;
    logic                   clr_req_reg;
    status_t                res_status_reg;
    logic [VALUE_BITS-1:0]  res_value_reg;
    logic                   m_valid_reg;
    status_t                m_status_reg;
    logic [VALUE_BITS-1:0]  m_found_reg;

    logic                   ram_we;
    logic [ENTRY_BITS-1:0]  ram_wdata;
    logic [ENTRY_BITS-1:0]  ram_rdata;
    logic [KEY_BITS-1:0]    slot_key;
    logic [VALUE_BITS-1:0]  slot_value;
    probe_res_t             probe;

    assign slot_key   = ram_rdata[ENTRY_BITS-1:VALUE_BITS];
    assign slot_value = ram_rdata[VALUE_BITS-1:0];

    ptbl_probe u_probe (
        .slot_key   (slot_key),
        .search_key (key_reg),
        .pos_reg    (pos_reg),
        .cnt_reg    (cnt_reg),
        .res        (probe),
        .pos_next   (pos_next),
        .cnt_next   (cnt_next)
    );

    // sweep writes empty slots, insert fills the first empty slot found
    always_comb begin
        ram_we = (state_reg == S_SWEEP)
              || (state_reg == S_CMP && req_reg == REQ_INSERT
                  && !probe.match && probe.empty);
        ram_wdata = (state_reg == S_SWEEP) ? '0 : {key_reg, value_reg};
    end

    ptbl_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (SLOT_COUNT)
    ) u_slots (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (pos_reg),
        .wr_data (ram_wdata),
        .rd_addr (pos_reg),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_SWEEP;
            pos_reg     <= '0;
            cnt_reg     <= '0;
            clr_req_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != S_RESP) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_SWEEP: begin
                    pos_reg <= pos_reg + 1'b1;
                    if (pos_reg == {SLOT_BITS{1'b1}}) begin
                        clr_req_reg    <= 1'b0;
                        res_status_reg <= STAT_CLEARED;
                        res_value_reg  <= '0;
                        state_reg      <= clr_req_reg ? S_RESP : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        req_reg       <= req_t'(s_req_type);
                        key_reg       <= s_key;
                        value_reg     <= s_entry_value;
                        cnt_reg       <= '0;
                        res_value_reg <= '0;
                        unique case (req_t'(s_req_type))
                            REQ_LOOKUP, REQ_INSERT: begin
                                if (s_key == '0) begin
                                    res_status_reg <= STAT_NULL;
                                    state_reg      <= S_RESP;
                                end else begin
                                    pos_reg   <= s_key[HOME_SHIFT +: SLOT_BITS];
                                    state_reg <= S_READ;
                                end
                            end
                            REQ_CLEAR: begin
                                pos_reg     <= '0;
                                clr_req_reg <= 1'b1;
                                state_reg   <= S_SWEEP;
                            end
                            default: begin
                                res_status_reg <= STAT_MISS;
                                state_reg      <= S_RESP;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    state_reg <= S_CMP;
                end
                S_CMP: begin
                    priority if (probe.match) begin
                        if (req_reg == REQ_LOOKUP) begin
                            res_status_reg <= STAT_HIT;
                            res_value_reg  <= slot_value;
                        end else begin
                            res_status_reg <= STAT_PRESENT;
                        end
                        state_reg <= S_RESP;
                    end else if (probe.empty) begin
                        res_status_reg <= (req_reg == REQ_LOOKUP) ? STAT_MISS
                                                                  : STAT_INSERTED;
                        state_reg <= S_RESP;
                    end else if (probe.exhausted) begin
                        res_status_reg <= (req_reg == REQ_LOOKUP) ? STAT_MISS
                                                                  : STAT_FULL;
                        state_reg <= S_RESP;
                    end else begin
                        pos_reg   <= pos_next;
                        cnt_reg   <= cnt_next;
                        state_reg <= S_READ;
                    end
                end
                S_RESP: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg   <= 1'b1;
                        m_status_reg  <= res_status_reg;
                        m_found_reg   <= res_value_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_found_value = m_found_reg;

    `ASSERT_NEVER(a_found_only_on_hit,
        m_valid && m_status != STAT_HIT && m_found_value != '0,
        "found value nonzero on a result that is not a hit")
    `ASSERT_NEVER(a_no_write_when_idle, ram_we && s_ready,
        "slot memory written while idle")
    `ASSERT_CLK(a_busy_after_accept, s_valid && s_ready |=> !s_ready,
        "ready still high after an item was accepted")
    `ASSERT_NEVER(a_no_probe_on_null, state_reg == S_CMP && key_reg == '0,
        "probe running for a null key")

endmodule
